@@ rtl/core/voxel_grid_line_of_sight_unit_assert.svh @@
// Assertion macros for the voxel grid line-of-sight unit
`ifndef VOXEL_GRID_LINE_OF_SIGHT_UNIT_ASSERT_SVH
`define VOXEL_GRID_LINE_OF_SIGHT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define VGLOS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vglos: implication check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define VGLOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vglos: next-cycle check failed");

`endif

@@ rtl/core/vglos_pkg.sv @@
// Shared types and constants for the voxel grid line-of-sight unit
package vglos_pkg;

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_TEST  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CELL_SIZE   = 2'd0;
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_GRID_DEPTH  = 2'd3;

    // Register reset values
    localparam logic [30:0] CELL_SIZE_RST = 31'd65536;
    localparam logic [6:0]  GRID_W_RST    = 7'd64;
    localparam logic [6:0]  GRID_H_RST    = 7'd64;
    localparam logic [4:0]  GRID_D_RST    = 5'd16;

    // Width of a clamped grid limit (sizes up to 2047)
    localparam int LIM_W = 11;
    // Divider word width and quotient bits per operation
    localparam int DIV_W = 32;
    // Saturated t value
    localparam logic [31:0] T_SAT = 32'hFFFF_FFFF;

    // Divider request
    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/core/vglos_divider.sv @@
// Shared restoring divider, one quotient bit per cycle
module vglos_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  vglos_pkg::div_req_t req,
    output vglos_pkg::div_stat_t stat,
    output logic [31:0]         quotient,
    output logic [31:0]         remainder
);

    logic [31:0] rem_reg;
    logic [31:0] sh_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, sh_reg[31]};
    assign fits  = trial >= {1'b0, den_reg};

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(vglos_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            sh_reg  <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= 32'(trial - {1'b0, den_reg});
                sh_reg  <= {sh_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                sh_reg  <= {sh_reg[30:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = sh_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/voxel_grid_line_of_sight_unit.sv @@
// Voxel grid line of sight: occupancy map and Amanatides-Woo segment walk
// Write: row read then bit merge in range, dropped out of range. Clear: all MAX_H*MAX_D rows.
// Test: setup of up to 12 divider runs (two floor divisions and two t ratios per axis,
// shared divider), then one map row read per cell step.
// One request at a time; the result register frees the input side before it is taken.
// Reset: async active low; map cleared by a pass over all MAX_H*MAX_D rows, no input taken.
module voxel_grid_line_of_sight_unit #(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64,
    parameter int MAX_D = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [30:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [5:0]         cell_x,
    input  logic [5:0]         cell_y,
    input  logic [3:0]         cell_z,
    input  logic               cell_value,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               path_blocked,
    output logic [7:0]         steps_taken,
    output logic               step_limit_hit
);

    localparam int XW         = (MAX_W > 1) ? $clog2(MAX_W) : 1;
    localparam int YW         = (MAX_H > 1) ? $clog2(MAX_H) : 1;
    localparam int ZW         = (MAX_D > 1) ? $clog2(MAX_D) : 1;
    localparam int ROWS       = MAX_H * MAX_D;
    localparam int RAW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STEP_LIMIT = MAX_W + MAX_H + MAX_D;
    localparam int SW         = $clog2(STEP_LIMIT + 1);
    localparam int LW         = vglos_pkg::LIM_W;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_READ,
        ST_WR_MOD,
        ST_FD0_GO,
        ST_FD0_WAIT,
        ST_FD1_GO,
        ST_FD1_WAIT,
        ST_TM_GO,
        ST_TM_WAIT,
        ST_TD_GO,
        ST_TD_WAIT,
        ST_AXIS_NEXT,
        ST_READ,
        ST_EVAL,
        ST_STEP,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [30:0] cell_size_reg;
    logic [6:0]  grid_width_reg;
    logic [6:0]  grid_height_reg;
    logic [4:0]  grid_depth_reg;

    // Request and walk state
    logic [RAW-1:0]     clr_reg;
    logic [XW-1:0]      wx_reg;
    logic [RAW-1:0]     wrow_reg;
    logic               wv_reg;
    logic [31:0]        cs_reg;
    logic signed [31:0] p0_reg [3];
    logic signed [31:0] p1_reg [3];
    logic signed [31:0] cell_reg [3];
    logic signed [31:0] end_reg [3];
    logic [31:0]        tmax_reg [3];
    logic [31:0]        tdelta_reg [3];
    logic               inf_reg [3];
    logic               dir_reg [3];
    logic [1:0]         axis_reg;
    logic [31:0]        r0_reg;
    logic [31:0]        num_reg;
    logic [31:0]        den_reg;
    logic [SW-1:0]      steps_reg;
    logic               hit_reg;
    logic               limit_reg;

    // Result register
    logic               out_valid_reg;
    logic               path_blocked_reg;
    logic [7:0]         steps_taken_reg;
    logic               step_limit_hit_reg;

    // Occupancy map, one row of MAX_W cells per (y, z)
    logic [MAX_W-1:0]   mem [ROWS];
    logic [MAX_W-1:0]   rdata_reg;
    logic               mem_we;
    logic [RAW-1:0]     mem_wrow;
    logic [MAX_W-1:0]   mem_wdata;
    logic [RAW-1:0]     mem_rrow;
    logic [RAW-1:0]     walk_row;
    logic [MAX_W-1:0]   row_mod;

    // Divider hookup
    vglos_pkg::div_req_t  div_req;
    vglos_pkg::div_stat_t div_stat;
    logic [31:0]          div_q;
    logic [31:0]          div_r;

    // Setup datapath
    logic signed [31:0] p0_sel;
    logic signed [31:0] p1_sel;
    logic [31:0]        abs0;
    logic [31:0]        abs1;
    logic               fd_neg;
    logic signed [31:0] floor_cell;
    logic [31:0]        floor_rem;
    logic [32:0]        diff;
    logic [31:0]        den_val;
    logic               dir_val;
    logic [31:0]        ratio_num;
    logic               ratio_sat;

    // Walk datapath
    logic [LW-1:0]      lim_w;
    logic [LW-1:0]      lim_h;
    logic [LW-1:0]      lim_d;
    logic               in_grid;
    logic               cell_free;
    logic               at_end;
    logic               x_lt_y;
    logic               x_lt_z;
    logic               y_lt_z;
    logic [1:0]         sel;
    logic [32:0]        t_sum;
    logic               wr_in_range;
    logic               in_xfer;

    // True if axis a's tMax is strictly below axis b's
    function automatic logic t_less(input logic inf_a, input logic [31:0] t_a,
                                    input logic inf_b, input logic [31:0] t_b);
        return !inf_a && (inf_b || (t_a < t_b));
    endfunction

    // Cell index inside [0, lim)
    function automatic logic axis_ok(input logic signed [31:0] c, input logic [LW-1:0] lim);
        return !c[31] && ($unsigned(c) < 32'(lim));
    endfunction

    vglos_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_q),
        .remainder(div_r)
    );

    // Grid limits clamped to the map size
    assign lim_w = (32'(grid_width_reg) > 32'(MAX_W)) ? LW'(MAX_W) : LW'(grid_width_reg);
    assign lim_h = (32'(grid_height_reg) > 32'(MAX_H)) ? LW'(MAX_H) : LW'(grid_height_reg);
    assign lim_d = (32'(grid_depth_reg) > 32'(MAX_D)) ? LW'(MAX_D) : LW'(grid_depth_reg);

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign wr_in_range = (32'(cell_x) < 32'(lim_w)) && (32'(cell_y) < 32'(lim_h))
                         && (32'(cell_z) < 32'(lim_d));

    // Axis operand select for setup
    assign p0_sel = p0_reg[axis_reg];
    assign p1_sel = p1_reg[axis_reg];
    assign abs0   = p0_sel[31] ? (32'd0 - $unsigned(p0_sel)) : $unsigned(p0_sel);
    assign abs1   = p1_sel[31] ? (32'd0 - $unsigned(p1_sel)) : $unsigned(p1_sel);

    // Floor division fix-up of the magnitude quotient
    assign fd_neg     = (state_reg == ST_FD0_WAIT) ? p0_sel[31] : p1_sel[31];
    assign floor_cell = fd_neg ? $signed(32'(33'd0 - {1'b0, div_q} - 33'(div_r != 32'd0)))
                               : $signed(div_q);
    assign floor_rem  = (fd_neg && (div_r != 32'd0)) ? (cs_reg - div_r) : div_r;

    // Segment extent and step direction on this axis
    assign diff    = {p1_sel[31], p1_sel} - {p0_sel[31], p0_sel};
    assign den_val = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
    assign dir_val = cell_reg[axis_reg] < floor_cell;

    // t ratio operand, saturates when num >= 4*den
    assign ratio_num = (state_reg == ST_TD_GO) ? cs_reg : num_reg;
    assign ratio_sat = {2'b00, ratio_num} >= {den_reg, 2'b00};

    // Divider request
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            ST_FD0_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = abs0;
                div_req.divisor  = cs_reg;
            end
            ST_FD1_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = abs1;
                div_req.divisor  = cs_reg;
            end
            ST_TM_GO, ST_TD_GO:
            begin
                div_req.start    = !ratio_sat;
                div_req.rem_init = ratio_num >> 2;
                div_req.dividend = {ratio_num[1:0], 30'd0};
                div_req.divisor  = den_reg;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    // Walk decisions
    assign in_grid   = axis_ok(cell_reg[0], lim_w) && axis_ok(cell_reg[1], lim_h)
                       && axis_ok(cell_reg[2], lim_d);
    assign cell_free = in_grid && !rdata_reg[cell_reg[0][XW-1:0]];
    assign at_end    = (cell_reg[0] == end_reg[0]) && (cell_reg[1] == end_reg[1])
                       && (cell_reg[2] == end_reg[2]);
    assign x_lt_y    = t_less(inf_reg[0], tmax_reg[0], inf_reg[1], tmax_reg[1]);
    assign x_lt_z    = t_less(inf_reg[0], tmax_reg[0], inf_reg[2], tmax_reg[2]);
    assign y_lt_z    = t_less(inf_reg[1], tmax_reg[1], inf_reg[2], tmax_reg[2]);
    assign sel       = (x_lt_y && x_lt_z) ? 2'd0 : (y_lt_z ? 2'd1 : 2'd2);
    assign t_sum     = {1'b0, tmax_reg[sel]} + {1'b0, tdelta_reg[sel]};

    // Map addressing
    assign walk_row = RAW'(cell_reg[2][ZW-1:0]) * RAW'(MAX_H) + RAW'(cell_reg[1][YW-1:0]);
    assign mem_rrow = (state_reg == ST_WR_READ) ? wrow_reg : walk_row;

    always_comb
    begin
        row_mod         = rdata_reg;
        row_mod[wx_reg] = wv_reg;
    end

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WR_MOD);
    assign mem_wrow  = (state_reg == ST_CLEAR) ? clr_reg : wrow_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : row_mod;

    // Map storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wrow] <= mem_wdata;
        end
        rdata_reg <= mem[mem_rrow];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg   <= vglos_pkg::CELL_SIZE_RST;
            grid_width_reg  <= vglos_pkg::GRID_W_RST;
            grid_height_reg <= vglos_pkg::GRID_H_RST;
            grid_depth_reg  <= vglos_pkg::GRID_D_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                vglos_pkg::CFG_CELL_SIZE:   cell_size_reg   <= cfg_wdata;
                vglos_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[6:0];
                vglos_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[6:0];
                vglos_pkg::CFG_GRID_DEPTH:  grid_depth_reg  <= cfg_wdata[4:0];
                default:                    cell_size_reg   <= cell_size_reg;
            endcase
        end
    end

    // Sequencer, datapath registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            steps_reg     <= '0;
        end
        else
        begin
            // Result taken; the finish state handles its own reload
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                // Zero one map row per cycle
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + RAW'(1);
                    if (clr_reg == RAW'(ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (req_type)
                            vglos_pkg::REQ_WRITE:
                            begin
                                wx_reg   <= XW'(cell_x);
                                wrow_reg <= RAW'(cell_z) * RAW'(MAX_H) + RAW'(cell_y);
                                wv_reg   <= cell_value;
                                if (wr_in_range)
                                begin
                                    state_reg <= ST_WR_READ;
                                end
                            end
                            vglos_pkg::REQ_CLEAR:
                            begin
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            vglos_pkg::REQ_TEST:
                            begin
                                p0_reg[0] <= start_x;
                                p0_reg[1] <= start_y;
                                p0_reg[2] <= start_z;
                                p1_reg[0] <= end_x;
                                p1_reg[1] <= end_y;
                                p1_reg[2] <= end_z;
                                cs_reg    <= (cell_size_reg == 31'd0) ? 32'd1
                                                                      : {1'b0, cell_size_reg};
                                axis_reg  <= '0;
                                steps_reg <= '0;
                                hit_reg   <= 1'b0;
                                limit_reg <= 1'b0;
                                state_reg <= ST_FD0_GO;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // Row read in flight, then merge the new bit
                ST_WR_READ: state_reg <= ST_WR_MOD;
                ST_WR_MOD:  state_reg <= ST_IDLE;

                // Start cell on this axis
                ST_FD0_GO: state_reg <= ST_FD0_WAIT;
                ST_FD0_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        cell_reg[axis_reg] <= floor_cell;
                        r0_reg             <= floor_rem;
                        state_reg          <= ST_FD1_GO;
                    end
                end

                // End cell, then direction and ratio operands
                ST_FD1_GO: state_reg <= ST_FD1_WAIT;
                ST_FD1_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        end_reg[axis_reg] <= floor_cell;
                        dir_reg[axis_reg] <= dir_val;
                        den_reg           <= den_val;
                        num_reg           <= dir_val ? (cs_reg - r0_reg) : r0_reg;
                        if (cell_reg[axis_reg] == floor_cell)
                        begin
                            inf_reg[axis_reg]    <= 1'b1;
                            tmax_reg[axis_reg]   <= '0;
                            tdelta_reg[axis_reg] <= '0;
                            state_reg            <= ST_AXIS_NEXT;
                        end
                        else
                        begin
                            inf_reg[axis_reg] <= 1'b0;
                            state_reg         <= ST_TM_GO;
                        end
                    end
                end

                // tMax: distance to the first boundary over the extent
                ST_TM_GO:
                begin
                    if (ratio_sat)
                    begin
                        tmax_reg[axis_reg] <= vglos_pkg::T_SAT;
                        state_reg          <= ST_TD_GO;
                    end
                    else
                    begin
                        state_reg <= ST_TM_WAIT;
                    end
                end
                ST_TM_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        tmax_reg[axis_reg] <= div_q;
                        state_reg          <= ST_TD_GO;
                    end
                end

                // tDelta: cell size over the extent
                ST_TD_GO:
                begin
                    if (ratio_sat)
                    begin
                        tdelta_reg[axis_reg] <= vglos_pkg::T_SAT;
                        state_reg            <= ST_AXIS_NEXT;
                    end
                    else
                    begin
                        state_reg <= ST_TD_WAIT;
                    end
                end
                ST_TD_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        tdelta_reg[axis_reg] <= div_q;
                        state_reg            <= ST_AXIS_NEXT;
                    end
                end

                ST_AXIS_NEXT:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_FD0_GO;
                    end
                end

                // Row of the current cell lands in rdata_reg
                ST_READ: state_reg <= ST_EVAL;

                // Check current cell, end cell and step ceiling
                ST_EVAL:
                begin
                    if (!cell_free)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (at_end)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (32'(steps_reg) >= 32'(STEP_LIMIT))
                    begin
                        hit_reg   <= 1'b1;
                        limit_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_STEP;
                    end
                end

                // Advance the axis with the smallest tMax
                ST_STEP:
                begin
                    cell_reg[sel] <= cell_reg[sel] + (dir_reg[sel] ? 32'sd1 : -32'sd1);
                    tmax_reg[sel] <= t_sum[32] ? vglos_pkg::T_SAT : t_sum[31:0];
                    steps_reg     <= steps_reg + SW'(1);
                    state_reg     <= ST_READ;
                end

                // Load the result once the previous one is gone
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg      <= 1'b1;
                        path_blocked_reg   <= hit_reg;
                        steps_taken_reg    <= 8'(steps_reg);
                        step_limit_hit_reg <= limit_reg;
                        state_reg          <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign path_blocked   = path_blocked_reg;
    assign steps_taken    = steps_taken_reg;
    assign step_limit_hit = step_limit_hit_reg;

`include "voxel_grid_line_of_sight_unit_assert.svh"

    // No request is taken while the divider runs
    `VGLOS_ASSERT_IMPL(a_div_busy_not_ready, div_stat.busy, !in_ready)
    // A walk stopped at the ceiling always reports blocked
    `VGLOS_ASSERT_IMPL(a_limit_blocked, out_valid && step_limit_hit, path_blocked)
    // A segment test keeps the input side closed on the next cycle
    `VGLOS_ASSERT_NEXT(a_test_busy, in_xfer && (req_type == vglos_pkg::REQ_TEST), !in_ready)

endmodule

@@ tb/voxel_grid_line_of_sight_checker.sv @@
// Line-of-sight checker: predicts segment test outcomes from observed transfers and compares
`timescale 1ns / 100ps
module voxel_grid_line_of_sight_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [30:0]        cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [5:0]         cell_x,
    input  logic [5:0]         cell_y,
    input  logic [3:0]         cell_z,
    input  logic               cell_value,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               path_blocked,
    input  logic [7:0]         steps_taken,
    input  logic               step_limit_hit,
    output int                 fail_count,
    output int                 pending_count,
    output int                 verdict_count
);
    localparam int GW = 64;
    localparam int GH = 64;
    localparam int GD = 16;
    localparam int WALK_CEIL = GW + GH + GD;
    localparam longint TSAT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic       blocked;
        logic [7:0] steps;
        logic       ceil_hit;
    } verdict_t;

    typedef struct {
        longint cur;
        longint last;
        longint dir;
        longint tmax;
        longint tdelta;
        bit     flat;
    } walk_axis_t;

    bit         occ_map [GW*GH*GD];
    logic [30:0] csize;
    logic [6:0]  gw_reg, gh_reg;
    logic [4:0]  gd_reg;
    verdict_t    verdict_q[$];

    function automatic longint clamp_dim(longint v, longint m);
        return (v > m) ? m : v;
    endfunction

    function automatic bit open_cell(longint x, longint y, longint z);
        if (x < 0 || y < 0 || z < 0) return 1'b0;
        if (x >= clamp_dim(gw_reg, GW) || y >= clamp_dim(gh_reg, GH)
            || z >= clamp_dim(gd_reg, GD)) return 1'b0;
        return occ_map[(z*GH + y)*GW + x] == 0;
    endfunction

    function automatic longint t_quot(longint num, longint den);
        longint q;
        q = (num <<< 30) / den;
        return (q > TSAT) ? TSAT : q;
    endfunction

    function automatic walk_axis_t axis_init(longint p0, longint p1, longint cs);
        walk_axis_t a;
        longint r0, r1, den;
        a.cur = p0 / cs;
        r0 = p0 - a.cur*cs;
        if (r0 < 0) begin a.cur -= 1; r0 += cs; end
        a.last = p1 / cs;
        r1 = p1 - a.last*cs;
        if (r1 < 0) begin a.last -= 1; r1 += cs; end
        a.dir = (a.cur < a.last) ? 1 : -1;
        a.flat = (a.cur == a.last);
        a.tmax = 0;
        a.tdelta = 0;
        if (!a.flat) begin
            den = (p1 > p0) ? p1 - p0 : p0 - p1;
            a.tmax = t_quot((a.dir > 0) ? cs - r0 : r0, den);
            a.tdelta = t_quot(cs, den);
        end
        return a;
    endfunction

    function automatic bit earlier(walk_axis_t a, walk_axis_t b);
        if (a.flat) return 1'b0;
        if (b.flat) return 1'b1;
        return a.tmax < b.tmax;
    endfunction

    function automatic walk_axis_t step_axis(walk_axis_t a);
        longint s;
        s = a.tmax + a.tdelta;
        a.cur += a.dir;
        a.tmax = (s > TSAT) ? TSAT : s;
        return a;
    endfunction

    function automatic verdict_t trace_segment();
        walk_axis_t ax, ay, az;
        longint cs;
        int n;
        verdict_t v;
        cs = (csize == 0) ? 1 : longint'(csize);
        ax = axis_init(longint'(start_x), longint'(end_x), cs);
        ay = axis_init(longint'(start_y), longint'(end_y), cs);
        az = axis_init(longint'(start_z), longint'(end_z), cs);
        n = 0;
        v = '0;
        if (!open_cell(ax.cur, ay.cur, az.cur)) v.blocked = 1'b1;
        else begin
            while (ax.cur != ax.last || ay.cur != ay.last || az.cur != az.last) begin
                if (n >= WALK_CEIL) begin
                    v.blocked = 1'b1;
                    v.ceil_hit = 1'b1;
                    break;
                end
                if (earlier(ax, ay) && earlier(ax, az)) ax = step_axis(ax);
                else if (earlier(ay, az)) ay = step_axis(ay);
                else az = step_axis(az);
                n++;
                if (!open_cell(ax.cur, ay.cur, az.cur)) begin
                    v.blocked = 1'b1;
                    break;
                end
            end
        end
        v.steps = n[7:0];
        return v;
    endfunction

    assign pending_count = verdict_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp_v;
        if (!rst_n)
        begin
            foreach (occ_map[i]) occ_map[i] = 0;
            csize  = vglos_pkg::CELL_SIZE_RST;
            gw_reg = vglos_pkg::GRID_W_RST;
            gh_reg = vglos_pkg::GRID_H_RST;
            gd_reg = vglos_pkg::GRID_D_RST;
            verdict_q.delete();
            fail_count    <= 0;
            verdict_count <= 0;
        end
        else
        begin
            // register writes
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    vglos_pkg::CFG_CELL_SIZE:   csize  = cfg_wdata;
                    vglos_pkg::CFG_GRID_WIDTH:  gw_reg = cfg_wdata[6:0];
                    vglos_pkg::CFG_GRID_HEIGHT: gh_reg = cfg_wdata[6:0];
                    vglos_pkg::CFG_GRID_DEPTH:  gd_reg = cfg_wdata[4:0];
                    default: ;
                endcase
            end
            // result transfer against oldest prediction
            if (out_valid && out_ready)
            begin
                verdict_count <= verdict_count + 1;
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected result transfer");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    if (exp_v.blocked !== path_blocked || exp_v.steps !== steps_taken
                        || exp_v.ceil_hit !== step_limit_hit)
                        fail_count <= fail_count + 1;
                    if (exp_v.blocked !== path_blocked)
                        $error("path_blocked exp %0d got %0d", exp_v.blocked, path_blocked);
                    if (exp_v.steps !== steps_taken)
                        $error("steps_taken exp %0d got %0d", exp_v.steps, steps_taken);
                    if (exp_v.ceil_hit !== step_limit_hit)
                        $error("step_limit_hit exp %0d got %0d", exp_v.ceil_hit,
                               step_limit_hit);
                end
            end
            // request transfer
            if (in_valid && in_ready)
            begin
                case (req_type)
                    vglos_pkg::REQ_WRITE:
                        if (cell_x < clamp_dim(gw_reg, GW) && cell_y < clamp_dim(gh_reg, GH)
                            && cell_z < clamp_dim(gd_reg, GD))
                            occ_map[(cell_z*GH + cell_y)*GW + cell_x] = cell_value;
                    vglos_pkg::REQ_CLEAR: foreach (occ_map[i]) occ_map[i] = 0;
                    vglos_pkg::REQ_TEST:  verdict_q.push_back(trace_segment());
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ tb/voxel_grid_line_of_sight_unit_tb.sv @@
// Testbench top: request stimulus, register phases, output stalls and verdict
`timescale 1ns / 100ps
module voxel_grid_line_of_sight_unit_tb;

    logic clk, rst_n;
    logic cfg_wr_en;
    logic [1:0] cfg_addr;
    logic [30:0] cfg_wdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0] req_type;
    logic [5:0] cell_x, cell_y;
    logic [3:0] cell_z;
    logic cell_value;
    logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic path_blocked, step_limit_hit;
    logic [7:0] steps_taken;
    int fail_count, pending_count, verdict_count;

    voxel_grid_line_of_sight_unit dut (.*);
    voxel_grid_line_of_sight_checker chk (.*);

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // one request transfer, then a random gap
    task automatic send_req(input logic [1:0] rt, input logic [5:0] x, input logic [5:0] y,
                            input logic [3:0] z, input logic v,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] sz, input logic [31:0] ex,
                            input logic [31:0] ey, input logic [31:0] ez);
        int gap;
        in_valid <= 1'b1;
        req_type <= rt; cell_x <= x; cell_y <= y; cell_z <= z; cell_value <= v;
        start_x <= sx; start_y <= sy; start_z <= sz;
        end_x <= ex; end_y <= ey; end_z <= ez;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120)
            : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cell(input int x, input int y, input int z, input bit v);
        send_req(vglos_pkg::REQ_WRITE, 6'(x), 6'(y), 4'(z), v, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    endtask

    task automatic test_seg(input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] sz, input logic [31:0] ex,
                            input logic [31:0] ey, input logic [31:0] ez);
        send_req(vglos_pkg::REQ_TEST, 6'($urandom), 6'($urandom), 4'($urandom), 1'($urandom),
                 sx, sy, sz, ex, ey, ez);
    endtask

    // request with random payload
    task automatic rand_req(input logic [1:0] rt);
        send_req(rt, 6'($urandom), 6'($urandom), 4'($urandom), 1'($urandom), $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // drain, settle, then write the registers while idle
    task automatic set_regs(input logic [30:0] cs, input logic [6:0] w, input logic [6:0] h,
                            input logic [4:0] d);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (2100) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= vglos_pkg::CFG_CELL_SIZE;   cfg_wdata <= cs;       @(posedge clk);
        cfg_addr <= vglos_pkg::CFG_GRID_WIDTH;  cfg_wdata <= 31'(w);   @(posedge clk);
        cfg_addr <= vglos_pkg::CFG_GRID_HEIGHT; cfg_wdata <= 31'(h);   @(posedge clk);
        cfg_addr <= vglos_pkg::CFG_GRID_DEPTH;  cfg_wdata <= 31'(d);   @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // random coordinate scaled to the cell size, mostly near or inside the grid
    function automatic logic [31:0] rand_coord(input longint cs, input int cells);
        longint v;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default:
            begin
                v = longint'($urandom_range(0, (cells + 2) * 16)) * cs / 16 - cs;
                if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
                return v[31:0];
            end
        endcase
    endfunction

    task automatic random_phase(input int n, input longint cs, input int w, input int h,
                                input int d);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)
                write_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
                           $urandom_range(0, 3) != 0);
            else if (k < 42)
                rand_req(vglos_pkg::REQ_CLEAR);
            else if (k < 43)
                rand_req(2'd3);
            else
                test_seg(rand_coord(cs, w), rand_coord(cs, h), rand_coord(cs, d),
                         rand_coord(cs, w), rand_coord(cs, h), rand_coord(cs, d));
        end
    endtask

    // output side stalls, including one long hold-off
    initial
    begin
        int r;
        out_ready = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        out_ready <= 1'b0;
        repeat (4000) @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 19);
            out_ready <= (r > 5) || (r < 2 ? 1'b0 : $urandom_range(0, 1));
            if (r == 0)
                repeat ($urandom_range(20, 300)) @(posedge clk);
            else
                @(posedge clk);
        end
    end

    initial
    begin
        cfg_wr_en = 0; cfg_addr = vglos_pkg::CFG_CELL_SIZE; cfg_wdata = '0;
        in_valid = 0; req_type = vglos_pkg::REQ_WRITE; cell_x = 0; cell_y = 0; cell_z = 0;
        cell_value = 0; start_x = 0; start_y = 0; start_z = 0;
        end_x = 0; end_y = 0; end_z = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, unit cells
        test_seg(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        test_seg(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                 32'h003F_8000, 32'h003F_8000, 32'h000F_8000);
        test_seg(32'hFFFF_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0);
        test_seg(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0005_0000, 32'h0005_0000, 32'h0005_0000);
        test_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_cell(63, 63, 15, 1);
        write_cell(3, 0, 0, 1);
        test_seg(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                 32'h0008_8000, 32'h0000_8000, 32'h0000_8000);
        test_seg(32'h003F_8000, 32'h003F_8000, 32'h000F_8000,
                 32'h003F_8000, 32'h003F_8000, 32'h000F_8000);
        send_req(2'd3, 6'h3F, 6'h3F, 4'hF, 1'b1, '1, '1, '1, '1, '1, '1);
        send_req(vglos_pkg::REQ_CLEAR, 6'd0, 6'd0, 4'd0, 1'b0, 32'd0, 32'd0, 32'd0,
                 32'd0, 32'd0, 32'd0);
        test_seg(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                 32'h0008_8000, 32'h0000_8000, 32'h0000_8000);
        write_cell(3, 0, 0, 0);
        random_phase(450, 65536, 64, 64, 16);

        // tiny cells: long walks across the grid and out of it
        set_regs(31'd1, 7'd64, 7'd64, 5'd16);
        test_seg(32'd0, 32'd0, 32'd0, 32'd60, 32'd60, 32'd15);
        test_seg(32'd0, 32'd0, 32'd0, 32'd2000, 32'd1, 32'd0);
        random_phase(250, 1, 64, 64, 16);

        // zero cell size, oversized grid registers
        set_regs(31'd0, 7'd127, 7'd100, 5'd31);
        test_seg(32'd0, 32'd0, 32'd0, 32'd50, 32'd70, 32'd20);
        random_phase(200, 1, 64, 64, 16);

        // huge cells, minimal grid
        set_regs(31'h7FFF_FFFF, 7'd1, 7'd1, 5'd1);
        write_cell(1, 0, 0, 1);
        random_phase(250, 64'h7FFF_FFFF, 1, 1, 1);

        // zero-size grid: everything out of bounds
        set_regs(31'd65536, 7'd0, 7'd5, 5'd0);
        random_phase(100, 65536, 1, 5, 1);

        // small grid, fractional cells
        set_regs(31'd20000 + 31'($urandom_range(0, 30000)), 7'd9, 7'd13, 5'd5);
        random_phase(450, 30000, 9, 13, 5);

        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #150ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
